// ----- src/mfam_pkg.sv -----
// Package with shared types and constants of the max-flow adjacency matrix unit.
`default_nettype none
package mfam_pkg;
  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_ENTRY_BITS = 24;
  localparam int NODE_W = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W = 16;
  localparam int FLOW_W = 27;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_SOURCE = 2'd1,
    CFG_SINK = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALU_ADD_SAT,
    ALU_SUB,
    ALU_MIN
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DEQ,
    S_SCAN,
    S_PRD,
    S_PCMP,
    S_URD,
    S_UWR1,
    S_UWR2,
    S_ACC,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// ----- src/mfam_if.sv -----
// Channel interfaces for edge requests and flow results.
`default_nettype none
interface mfam_edge_if;
  import mfam_pkg::*;
  logic valid;
  logic ready;
  logic [NODE_W-1:0] edge_from;
  logic [NODE_W-1:0] edge_to;
  logic [CAP_W-1:0] edge_capacity;
  logic is_last;
  modport source(output valid, edge_from, edge_to, edge_capacity, is_last, input ready);
  modport sink(input valid, edge_from, edge_to, edge_capacity, is_last, output ready);
endinterface

interface mfam_flow_if;
  import mfam_pkg::*;
  logic valid;
  logic ready;
  logic [FLOW_W-1:0] total_flow;
  logic bad_setting;
  modport source(output valid, total_flow, bad_setting, input ready);
  modport sink(input valid, total_flow, bad_setting, output ready);
endinterface
`default_nettype wire

// ----- src/mfam_alu.sv -----
// Shared saturating add, subtract and minimum unit for matrix entries.
`default_nettype none
module mfam_alu
  import mfam_pkg::*;
#(
  parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
  input  wire alu_op_t               op,
  input  wire logic [ENTRY_BITS-1:0] a,
  input  wire logic [((ENTRY_BITS > CAP_W) ? ENTRY_BITS : CAP_W)-1:0] b,
  output logic [ENTRY_BITS-1:0]      y
);
  localparam int OPW = (ENTRY_BITS > CAP_W) ? ENTRY_BITS : CAP_W;
  localparam logic [OPW:0] EMAX = (OPW+1)'((64'd1 << (ENTRY_BITS - 1)) - 64'd1);

  logic [OPW:0] sum;
  logic [OPW:0] a_ext;

  assign a_ext = (OPW+1)'(a);
  assign sum = a_ext + (OPW+1)'(b);

  always_comb begin
    case (op)
      ALU_ADD_SAT: y = (sum > EMAX) ? EMAX[ENTRY_BITS-1:0] : sum[ENTRY_BITS-1:0];
      ALU_SUB: y = a - b[ENTRY_BITS-1:0];
      ALU_MIN: y = (a_ext < (OPW+1)'(b)) ? a : b[ENTRY_BITS-1:0];
      default: y = a;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/mfam_matrix.sv -----
// Capacity matrix memory with per-entry valid bits and a bypassed registered read.
`default_nettype none
module mfam_matrix
  import mfam_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 clr,
  input  wire logic                                 we,
  input  wire logic [2*$clog2(MAX_NODES)-1:0]       waddr,
  input  wire logic [ENTRY_BITS-1:0]                wdata,
  input  wire logic [2*$clog2(MAX_NODES)-1:0]       raddr,
  output logic [ENTRY_BITS-1:0]                     rdata
);
  localparam int AW = 2 * $clog2(MAX_NODES);
  localparam int DEPTH = 1 << AW;

  logic [ENTRY_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [ENTRY_BITS-1:0] rd_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  logic byp_r;
  logic [ENTRY_BITS-1:0] byp_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      byp_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr] && !clr;
      byp_r <= we && (waddr == raddr) && !clr;
    end
    byp_data_r <= wdata;
  end

  assign rdata = byp_r ? byp_data_r : (rd_vld_r ? rd_r : '0);
endmodule
`default_nettype wire

// ----- src/max_flow_adjacency_matrix_unit.sv -----
// Top level of the max-flow unit: edge loading, search sequencer and result register.
//
//  Port     Dir  Handshake      Content
//  in_ch    in   valid/ready    edge_from, edge_to, edge_capacity, is_last
//  out_ch   out  valid/ready    total_flow, bad_setting
//  cfg_*    in   cfg_we only    node_count, source_node, sink_node
//
// Edge requests are taken one per cycle while the unit is idle. A request marked last holds
// in_ch.ready low while the search runs, which does every node scan and every path
// update through one matrix read port.
// Reset is synchronous; it clears the matrix valid bits at once.
// A result waits in its output register; new edges are taken meanwhile.
`default_nettype none
module max_flow_adjacency_matrix_unit
  import mfam_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mfam_edge_if.sink                  in_ch,
  mfam_flow_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = 2 * NW;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int OPW = (ENTRY_BITS > CAP_W) ? ENTRY_BITS : CAP_W;
  localparam int SUM_W = ((ENTRY_BITS > FLOW_W) ? ENTRY_BITS : FLOW_W) + 1;
  localparam logic [ENTRY_BITS-1:0] EMAX = ENTRY_BITS'((64'd1 << (ENTRY_BITS - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] FMAX = SUM_W'((64'd1 << FLOW_W) - 64'd1);

  state_t state_r, state_nxt;
  logic [COUNT_W-1:0] ncnt_r;
  logic [NODE_W-1:0] src_r, snk_r;
  logic ld_vld_r;
  logic [AW-1:0] ld_addr_r;
  logic [CAP_W-1:0] ld_cap_r;
  logic [NW-1:0] u_r, u_nxt, w_r, w_nxt, chk_v_r;
  logic [CNT_W-1:0] v_r, v_nxt, head_r, head_nxt, tail_r;
  logic chk_vld_r, chk_vld_nxt;
  logic [MAX_NODES-1:0] visited_r;
  logic [NW-1:0] parent_r [MAX_NODES];
  logic [NW-1:0] queue_r [MAX_NODES];
  logic [ENTRY_BITS-1:0] push_r, push_nxt;
  logic [FLOW_W-1:0] flow_r, flow_nxt;
  logic out_vld_r;
  logic [FLOW_W-1:0] out_flow_r;
  logic out_bad_r;

  logic [CMP_W-1:0] n_eff, src_ext, snk_ext, from_ext, to_ext, v_ext;
  logic [NW-1:0] src_i, snk_i, pw;
  logic in_acc, edge_ok, cfg_bad, do_result;
  logic mem_we, mem_clr;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [ENTRY_BITS-1:0] mem_wdata, mem_rdata, alu_y, alu_a;
  logic [OPW-1:0] alu_b;
  alu_op_t alu_op;
  logic [SUM_W-1:0] flow_sum;

  assign n_eff = (CMP_W'(ncnt_r) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : CMP_W'(ncnt_r);
  assign src_ext = CMP_W'(src_r);
  assign snk_ext = CMP_W'(snk_r);
  assign from_ext = CMP_W'(in_ch.edge_from);
  assign to_ext = CMP_W'(in_ch.edge_to);
  assign v_ext = CMP_W'(v_r);
  assign src_i = src_ext[NW-1:0];
  assign snk_i = snk_ext[NW-1:0];
  assign pw = parent_r[w_r];
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign edge_ok = (from_ext < n_eff) && (to_ext < n_eff);
  assign cfg_bad = (src_r == snk_r) || (src_ext >= n_eff) || (snk_ext >= n_eff);
  assign do_result = (state_r == S_DONE) && (!out_vld_r || out_ch.ready);
  assign flow_sum = SUM_W'(flow_r) + SUM_W'(push_r);

  mfam_alu #(.ENTRY_BITS(ENTRY_BITS)) u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y)
  );

  mfam_matrix #(.MAX_NODES(MAX_NODES), .ENTRY_BITS(ENTRY_BITS)) u_matrix (
    .clk(clk), .rst_n(rst_n), .clr(mem_clr), .we(mem_we), .waddr(mem_waddr),
    .wdata(mem_wdata), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncnt_r <= COUNT_W'(16);
      src_r <= '0;
      snk_r <= NODE_W'(15);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_NODE_COUNT: ncnt_r <= cfg_wdata[COUNT_W-1:0];
        CFG_SOURCE: src_r <= cfg_wdata[NODE_W-1:0];
        CFG_SINK: snk_r <= cfg_wdata[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && in_ch.is_last) state_nxt = cfg_bad ? S_DONE : S_INIT;
      S_INIT: state_nxt = S_DEQ;
      S_DEQ: begin
        if (head_r < tail_r) state_nxt = S_SCAN;
        else if (visited_r[snk_i]) state_nxt = S_PRD;
        else state_nxt = S_DONE;
      end
      S_SCAN: if (v_ext >= n_eff && !chk_vld_r) state_nxt = S_DEQ;
      S_PRD: state_nxt = S_PCMP;
      S_PCMP: state_nxt = (pw == src_i) ? S_URD : S_PRD;
      S_URD: state_nxt = S_UWR1;
      S_UWR1: state_nxt = S_UWR2;
      S_UWR2: state_nxt = (pw == src_i) ? S_ACC : S_URD;
      S_ACC: state_nxt = S_INIT;
      S_DONE: if (do_result) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    w_nxt = w_r;
    head_nxt = head_r;
    chk_vld_nxt = 1'b0;
    push_nxt = push_r;
    flow_nxt = flow_r;
    mem_we = 1'b0;
    mem_clr = do_result;
    mem_waddr = ld_addr_r;
    mem_wdata = alu_y;
    mem_raddr = {from_ext[NW-1:0], to_ext[NW-1:0]};
    alu_op = ALU_ADD_SAT;
    alu_a = mem_rdata;
    alu_b = OPW'(ld_cap_r);
    if (ld_vld_r) begin
      mem_we = 1'b1;
    end
    case (state_r)
      S_INIT: head_nxt = '0;
      S_DEQ: begin
        if (head_r < tail_r) begin
          u_nxt = queue_r[head_r[NW-1:0]];
          head_nxt = head_r + 1'b1;
          v_nxt = '0;
        end else begin
          w_nxt = snk_i;
          push_nxt = EMAX;
        end
      end
      S_SCAN: begin
        mem_raddr = {u_r, v_r[NW-1:0]};
        if (v_ext < n_eff) begin
          chk_vld_nxt = 1'b1;
          v_nxt = v_r + 1'b1;
        end
      end
      S_PRD: mem_raddr = {pw, w_r};
      S_PCMP: begin
        alu_op = ALU_MIN;
        alu_a = push_r;
        alu_b = OPW'(mem_rdata);
        push_nxt = alu_y;
        w_nxt = (pw == src_i) ? snk_i : pw;
      end
      S_URD: mem_raddr = {pw, w_r};
      S_UWR1: begin
        alu_op = ALU_SUB;
        alu_b = OPW'(push_r);
        mem_we = 1'b1;
        mem_waddr = {pw, w_r};
        mem_raddr = {w_r, pw};
      end
      S_UWR2: begin
        alu_b = OPW'(push_r);
        mem_we = 1'b1;
        mem_waddr = {w_r, pw};
        w_nxt = pw;
      end
      S_ACC: flow_nxt = (flow_sum > FMAX) ? FMAX[FLOW_W-1:0] : flow_sum[FLOW_W-1:0];
      S_DONE: if (do_result) flow_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ld_vld_r <= 1'b0;
      chk_vld_r <= 1'b0;
      flow_r <= '0;
      out_vld_r <= 1'b0;
      visited_r <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      state_r <= state_nxt;
      ld_vld_r <= in_acc && edge_ok;
      chk_vld_r <= chk_vld_nxt;
      flow_r <= flow_nxt;
      head_r <= head_nxt;
      if (do_result) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
      if (state_r == S_INIT) begin
        visited_r <= MAX_NODES'(1) << src_i;
        tail_r <= CNT_W'(1);
      end else if (chk_vld_r && mem_rdata != '0 && !visited_r[chk_v_r]) begin
        visited_r[chk_v_r] <= 1'b1;
        if (tail_r < CNT_W'(MAX_NODES)) tail_r <= tail_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ld_addr_r <= {from_ext[NW-1:0], to_ext[NW-1:0]};
    ld_cap_r <= in_ch.edge_capacity;
    u_r <= u_nxt;
    v_r <= v_nxt;
    w_r <= w_nxt;
    push_r <= push_nxt;
    chk_v_r <= v_r[NW-1:0];
    if (state_r == S_INIT) begin
      queue_r[0] <= src_i;
    end else if (chk_vld_r && mem_rdata != '0 && !visited_r[chk_v_r]) begin
      parent_r[chk_v_r] <= u_r;
      if (tail_r < CNT_W'(MAX_NODES)) queue_r[tail_r[NW-1:0]] <= chk_v_r;
    end
    if (do_result) begin
      out_flow_r <= cfg_bad ? '0 : flow_r;
      out_bad_r <= (src_r == snk_r);
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.total_flow = out_flow_r;
  assign out_ch.bad_setting = out_bad_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_bad_r |-> out_flow_r == '0)
    else $error("bad setting with nonzero flow");
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.is_last |=> !in_ch.ready)
    else $error("input still ready after last edge");
  a_src_visited: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEQ |-> visited_r[src_i])
    else $error("source not visited during search");
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= CNT_W'(MAX_NODES) && head_r <= tail_r)
    else $error("queue pointers out of range");
endmodule
`default_nettype wire
